>>> hdl/gf256_mul_inv_order_unit_macros.svh
// Assertion macros for the asserting top file of the GF(2^8) unit.
`ifndef GF256_MUL_INV_ORDER_UNIT_MACROS_SVH
`define GF256_MUL_INV_ORDER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GFMIO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GFMIO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/gfmio_pkg.sv
package gfmio_pkg;

    // Operation codes carried in the kind field
    localparam logic [1:0] KIND_MUL = 2'd0;
    localparam logic [1:0] KIND_INV = 2'd1;
    localparam logic [1:0] KIND_ORD = 2'd2;

    // Field constants: reduction term, top bit, unity
    localparam logic [7:0] FIELD_REDUCE = 8'h1b;
    localparam logic [7:0] FIELD_TOP    = 8'h80;
    localparam logic [7:0] FIELD_ONE    = 8'h01;

    // Last squaring round of the inverse chain (seven rounds)
    localparam logic [2:0] INV_LAST  = 3'd6;
    // Largest possible order count
    localparam logic [7:0] COUNT_MAX = 8'hff;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_INV_SQ,
        ST_INV_ACC,
        ST_ORD,
        ST_FIN
    } t_state;

    // Operand selection and destination of the shared multiplier
    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_PROD,
        MOP_SQ,
        MOP_ACC,
        MOP_ORD
    } t_mul_op;

    typedef struct packed {
        logic    load;
        t_mul_op op;
        logic    store;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       a_zero;
        logic       run_one;
        logic       count_full;
    } t_dp_status;

endpackage

>>> hdl/gfmio_dp.sv
module gfmio_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gfmio_pkg::t_dp_cmd    i_cmd,
    output gfmio_pkg::t_dp_status o_status,
    input  logic [1:0]            i_kind,
    input  logic [7:0]            i_operand_a,
    input  logic [7:0]            i_operand_b,
    output logic [7:0]            o_result_byte,
    output logic [7:0]            o_element_order,
    output logic                  o_order_undefined
);

    // Shift-and-add field product, most significant bit of p first
    function automatic logic [7:0] gf_mul(input logic [7:0] p, input logic [7:0] q);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 7; i >= 0; i--) begin
            if ((acc & gfmio_pkg::FIELD_TOP) != 8'h00) begin
                acc = {acc[6:0], 1'b0} ^ gfmio_pkg::FIELD_REDUCE;
            end else begin
                acc = {acc[6:0], 1'b0};
            end
            if (p[i]) begin
                acc = acc ^ q;
            end
        end
        return acc;
    endfunction

    logic [1:0] r_kind;
    logic [7:0] r_a;
    logic [7:0] r_b;
    logic [7:0] r_acc;
    logic [7:0] r_sq;
    logic [7:0] r_run;
    logic [7:0] r_count;
    logic [7:0] r_res;
    logic [7:0] r_ord;
    logic       r_undef;

    logic [7:0] mul_x;
    logic [7:0] mul_y;
    logic [7:0] mul_p;

    // Select the operands of the shared multiplier
    always_comb begin
        mul_x = r_acc;
        mul_y = r_sq;
        unique case (i_cmd.op)
            gfmio_pkg::MOP_PROD: begin
                mul_x = r_a;
                mul_y = r_b;
            end
            gfmio_pkg::MOP_SQ: begin
                mul_x = r_sq;
                mul_y = r_sq;
            end
            gfmio_pkg::MOP_ACC: begin
                mul_x = r_acc;
                mul_y = r_sq;
            end
            gfmio_pkg::MOP_ORD: begin
                mul_x = r_run;
                mul_y = r_a;
            end
            default: begin
                mul_x = r_acc;
                mul_y = r_sq;
            end
        endcase
    end

    assign mul_p = gf_mul(mul_x, mul_y);

    // Capture operands, then advance the working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_a     <= i_operand_a;
            r_b     <= i_operand_b;
            r_acc   <= gfmio_pkg::FIELD_ONE;
            r_sq    <= i_operand_a;
            r_run   <= i_operand_a;
            r_count <= 8'd1;
        end else begin
            case (i_cmd.op)
                gfmio_pkg::MOP_PROD: r_acc <= mul_p;
                gfmio_pkg::MOP_SQ:   r_sq  <= mul_p;
                gfmio_pkg::MOP_ACC:  r_acc <= mul_p;
                gfmio_pkg::MOP_ORD: begin
                    r_run   <= mul_p;
                    r_count <= r_count + 8'd1;
                end
                default: ;
            endcase
        end
    end

    // Output register: fill from the finished operation
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            case (r_kind) inside
                gfmio_pkg::KIND_MUL, gfmio_pkg::KIND_INV: begin
                    r_res   <= r_acc;
                    r_ord   <= 8'd0;
                    r_undef <= 1'b0;
                end
                gfmio_pkg::KIND_ORD: begin
                    r_res   <= 8'd0;
                    r_ord   <= (r_a == 8'd0) ? 8'd0 : r_count;
                    r_undef <= (r_a == 8'd0);
                end
                default: begin
                    r_res   <= 8'd0;
                    r_ord   <= 8'd0;
                    r_undef <= 1'b0;
                end
            endcase
        end
    end

    assign o_status.kind       = r_kind;
    assign o_status.a_zero     = (r_a == 8'd0);
    assign o_status.run_one    = (r_run == gfmio_pkg::FIELD_ONE);
    assign o_status.count_full = (r_count == gfmio_pkg::COUNT_MAX);

    assign o_result_byte     = r_res;
    assign o_element_order   = r_ord;
    assign o_order_undefined = r_undef;

    // Reset reaches only the control side
    logic unused_rst;
    assign unused_rst = i_rst_n;

endmodule

>>> hdl/gfmio_ctrl.sv
module gfmio_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output gfmio_pkg::t_dp_cmd    o_cmd,
    input  gfmio_pkg::t_dp_status i_status
);

    gfmio_pkg::t_state r_state;
    gfmio_pkg::t_state n_state;
    logic [2:0]        r_iter;
    logic [2:0]        n_iter;
    logic              r_out_valid;
    logic              n_out_valid;

    // State, round counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gfmio_pkg::ST_IDLE;
            r_iter      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        o_in_ready  = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.op    = gfmio_pkg::MOP_NONE;
        o_cmd.store = 1'b0;
        unique case (r_state)
            gfmio_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = gfmio_pkg::ST_DECODE;
                end
            end
            gfmio_pkg::ST_DECODE: begin
                n_iter = 3'd0;
                unique case (i_status.kind)
                    gfmio_pkg::KIND_MUL: n_state = gfmio_pkg::ST_MUL;
                    gfmio_pkg::KIND_INV: n_state = gfmio_pkg::ST_INV_SQ;
                    gfmio_pkg::KIND_ORD: begin
                        n_state = i_status.a_zero ? gfmio_pkg::ST_FIN : gfmio_pkg::ST_ORD;
                    end
                    default: n_state = gfmio_pkg::ST_FIN;
                endcase
            end
            gfmio_pkg::ST_MUL: begin
                o_cmd.op = gfmio_pkg::MOP_PROD;
                n_state  = gfmio_pkg::ST_FIN;
            end
            gfmio_pkg::ST_INV_SQ: begin
                o_cmd.op = gfmio_pkg::MOP_SQ;
                n_state  = gfmio_pkg::ST_INV_ACC;
            end
            gfmio_pkg::ST_INV_ACC: begin
                o_cmd.op = gfmio_pkg::MOP_ACC;
                if (r_iter == gfmio_pkg::INV_LAST) begin
                    n_state = gfmio_pkg::ST_FIN;
                end else begin
                    n_iter  = r_iter + 3'd1;
                    n_state = gfmio_pkg::ST_INV_SQ;
                end
            end
            gfmio_pkg::ST_ORD: begin
                if (i_status.run_one || i_status.count_full) begin
                    n_state = gfmio_pkg::ST_FIN;
                end else begin
                    o_cmd.op = gfmio_pkg::MOP_ORD;
                end
            end
            gfmio_pkg::ST_FIN: begin
                // Hold until the output register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.store = 1'b1;
                    n_state     = gfmio_pkg::ST_IDLE;
                end
            end
            default: n_state = gfmio_pkg::ST_IDLE;
        endcase
    end

    // Output register occupancy
    always_comb begin
        if (o_cmd.store) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/gf256_mul_inv_order_unit.sv
// GF(2^8) arithmetic unit over the AES field (polynomial 0x11b). One input
// transaction gives one output transaction. Work runs on a single shared field
// multiplier, one product per cycle, one operation at a time; the output register
// lets a new transaction be taken while the previous result waits. From input
// acceptance to the result entering the output register, every kind passes a
// decode state and a finish state; multiply adds one product state, inverse seven
// square and accumulate rounds, and order the repeated multiply-by-operand loop.
// Order of zero and unused kind 3 go straight from decode to finish. The next
// input is accepted only once the controller is back in idle.
`include "gf256_mul_inv_order_unit_macros.svh"

module gf256_mul_inv_order_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [1:0] kind, [9:2] operand_a, [17:10] operand_b, [23:18] zero
    input  logic [23:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] result_byte, [15:8] element_order, [16] order_undefined, [23:17] zero
    output logic [23:0] o_m_axis_tdata
);

    gfmio_pkg::t_dp_cmd    cmd;
    gfmio_pkg::t_dp_status status;
    logic [7:0]            result_byte;
    logic [7:0]            element_order;
    logic                  order_undefined;
    logic [5:0]            unused_pad;

    assign unused_pad = i_s_axis_tdata[23:18];

    gfmio_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    gfmio_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_kind            (i_s_axis_tdata[1:0]),
        .i_operand_a       (i_s_axis_tdata[9:2]),
        .i_operand_b       (i_s_axis_tdata[17:10]),
        .o_result_byte     (result_byte),
        .o_element_order   (element_order),
        .o_order_undefined (order_undefined)
    );

    assign o_m_axis_tdata = {7'd0, order_undefined, element_order, result_byte};

    // One transaction at a time: no acceptance right after one
    `GFMIO_ASSERT_NEXT(a_single_item, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input accepted twice in a row")
    // An undefined order carries no order and no byte
    `GFMIO_ASSERT_NOW(a_undef_clean, i_clk, i_rst_n, o_m_axis_tvalid && order_undefined, element_order == 8'd0 && result_byte == 8'd0, "undefined order with nonzero fields")
    // An order result carries a zero byte
    `GFMIO_ASSERT_NOW(a_order_byte, i_clk, i_rst_n, o_m_axis_tvalid && element_order != 8'd0, result_byte == 8'd0 && !order_undefined, "order result with stray fields")

endmodule
